>>> sv/ffba_pkg.sv
package ffba_pkg;

    localparam int HEAP_PAGES_DEF   = 64;
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int GRANULE_BYTES    = 16;
    localparam int SPLIT_SLACK      = 32;

    localparam int SIZE_W     = 27;
    localparam int CLEN_W     = 19;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_INVALID = 2'd2,
        ST_NULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [63:0] result_pointer;
        logic        copy_valid;
        logic [63:0] copy_source;
        logic [18:0] copy_length;
    } t_result;

endpackage

>>> sv/ffba_mem.sv
module ffba_mem #(
    parameter int DEPTH  = 16384,
    parameter int WIDTH  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

>>> sv/first_fit_block_allocator.sv
// channel  | direction | payload
// s_axis   | in        | tdata: op[1:0], block_pointer[65:2], request_bytes[97:66]
// m_axis   | out       | tdata: status[1:0], result_pointer[65:2], copy_valid[66],
//          |           |        copy_source[130:67], copy_length[149:131]
// cfg      | in        | heap_base_address, written when i_cfg_wr_en
// one item at a time; an allocate walks the chain, one descriptor read at a
// time through the descriptor memory port (S_AREAD, then S_AWAIT). A free may
// read the next descriptor to merge with it; a growing reallocate allocates, then frees.
// after reset a clearing pass of one entry a cycle over the heap granules
// runs before the first item is taken; the result register holds under stall.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_PAGES   = HEAP_PAGES_DEF,
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op, block_pointer, request_bytes, zero fill
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, result_pointer, copy_valid, copy_source, copy_length, zero fill
    output logic [151:0] m_axis_tdata,
    input  logic         i_cfg_wr_en,
    input  logic [63:0]  i_cfg_wr_data
);
    localparam int NGRAN     = HEAP_PAGES * PAGE_BYTES / GRANULE_BYTES;
    localparam int GW        = $clog2(NGRAN);
    localparam int HDR_G     = HEADER_BYTES / GRANULE_BYTES;
    localparam longint HEAP_BYTES = longint'(HEAP_PAGES) * longint'(PAGE_BYTES);
    // descriptor: mark, free, has_next, next, size
    localparam int DW        = 3 + GW + SIZE_W;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_DECODE = 12'b000000000100,
        S_HREAD  = 12'b000000001000,
        S_HWAIT  = 12'b000000010000,
        S_AREAD  = 12'b000000100000,
        S_AWAIT  = 12'b000001000000,
        S_FNEXT  = 12'b000010000000,
        S_FWAIT  = 12'b000100000000,
        S_FMERGE = 12'b001000000000,
        S_SPLIT  = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } t_state;

    logic [GW-1:0] unused_w;
    assign unused_w = '0;

    t_state r_state, n_state;
    logic [63:0] r_base;
    logic [1:0]  r_op;
    logic [63:0] r_ptr;
    logic [31:0] r_req;
    logic [GW:0] r_cnt;
    logic [GW-1:0] r_g, r_old;
    logic [DW-1:0] r_oldd, r_cur;
    logic [SIZE_W-1:0] r_need;
    logic        r_realloc;
    logic        r_after_free;
    t_result     r_res;
    logic        r_ovalid;

    logic              rd_en, wr_en;
    logic [GW-1:0]     rd_addr, wr_addr;
    logic [DW-1:0]     rd_data, wr_data;

    ffba_mem #(.DEPTH(NGRAN), .WIDTH(DW)) u_mem (
        .i_clk(i_clk), .i_rd_en(rd_en), .i_rd_addr(rd_addr), .o_rd_data(rd_data),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data)
    );

    // descriptor field access
    function automatic logic d_mark(logic [DW-1:0] d); return d[DW-1]; endfunction
    function automatic logic d_free(logic [DW-1:0] d); return d[DW-2]; endfunction
    function automatic logic d_hn(logic [DW-1:0] d); return d[DW-3]; endfunction
    function automatic logic [GW-1:0] d_next(logic [DW-1:0] d);
        return d[SIZE_W +: GW];
    endfunction
    function automatic logic [SIZE_W-1:0] d_size(logic [DW-1:0] d);
        return d[SIZE_W-1:0];
    endfunction
    function automatic logic [DW-1:0] mk(logic m, logic f, logic h,
                                         logic [GW-1:0] nx, logic [SIZE_W-1:0] s);
        return {m, f, h, nx, s};
    endfunction

    // pointer decode
    logic [63:0] off, offh;
    logic        ptr_ok;
    assign off  = r_ptr - r_base;
    assign offh = off - 64'(HEADER_BYTES);
    assign ptr_ok = (off >= 64'(HEADER_BYTES)) && (offh[3:0] == 4'd0)
                    && (offh[63:4] < 60'(NGRAN));

    function automatic logic [63:0] uptr(logic [63:0] b, logic [GW-1:0] g);
        return b + {{(60-GW){1'b0}}, g, 4'd0} + 64'(HEADER_BYTES);
    endfunction

    logic [32:0] need_w;
    assign need_w = ({1'b0, r_req} + 33'd15) & ~33'd15;

    // walk candidate
    logic fits, split_ok;
    logic [GW+SIZE_W:0] ng_w;
    logic [SIZE_W+1:0] merged;
    assign fits = d_free(rd_data) && (d_size(rd_data) >= r_need);
    assign ng_w = (GW+SIZE_W+1)'(r_g) + (GW+SIZE_W+1)'(HDR_G)
                  + (GW+SIZE_W+1)'(r_need >> 4);
    assign split_ok = ({1'b0, d_size(rd_data)} >= {1'b0, r_need}
                      + (SIZE_W+1)'(HEADER_BYTES + SPLIT_SLACK))
                      && (ng_w < (GW+SIZE_W+1)'(NGRAN));
    assign merged = (SIZE_W+2)'(d_size(r_oldd)) + (SIZE_W+2)'(HEADER_BYTES)
                    + (SIZE_W+2)'(d_size(rd_data));

    always_comb begin
        n_state = r_state;
        rd_en = 1'b0; rd_addr = r_g;
        wr_en = 1'b0; wr_addr = r_g; wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = r_cnt[GW-1:0];
                wr_data = (r_cnt == '0)
                        ? mk(1'b1, 1'b1, 1'b0, unused_w, SIZE_W'(HEAP_BYTES - HEADER_BYTES))
                        : '0;
                if (r_cnt == (GW+1)'(NGRAN-1)) n_state = S_IDLE;
            end
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = S_DECODE;
            S_DECODE: n_state = S_HREAD;
            S_HREAD: begin
                rd_en = 1'b1;
                rd_addr = (r_op == OP_ALLOC || r_ptr == '0) ? '0 : offh[4 +: GW];
                n_state = S_HWAIT;
            end
            S_AREAD: begin rd_en = 1'b1; n_state = S_AWAIT; end
            S_FNEXT: begin rd_en = 1'b1; rd_addr = d_next(r_oldd); n_state = S_FWAIT; end
            S_FWAIT: begin
                wr_en = 1'b1; wr_addr = r_old;
                if (d_free(rd_data) && d_hn(r_oldd) && d_mark(rd_data)) begin
                    wr_data = mk(1'b1, 1'b1, d_hn(rd_data), d_next(rd_data),
                        (merged > (SIZE_W+2)'(HEAP_BYTES)) ? SIZE_W'(HEAP_BYTES)
                                                          : merged[SIZE_W-1:0]);
                end else begin
                    wr_data = mk(1'b1, 1'b1, d_hn(r_oldd), d_next(r_oldd), d_size(r_oldd));
                end
                n_state = S_OUT;
            end
            S_SPLIT: begin
                wr_en = 1'b1; wr_addr = r_g;
                wr_data = mk(1'b1, 1'b0, 1'b1, d_next(r_cur), r_need);
                n_state = r_realloc ? S_FNEXT : S_OUT;
            end
            default: ;
        endcase
        // write paths from the wait states are driven here, from the read data
        if (r_state == S_AWAIT && fits) begin
            wr_en = 1'b1;
            if (split_ok) begin
                wr_addr = ng_w[GW-1:0];
                wr_data = mk(1'b1, 1'b1, d_hn(rd_data), d_next(rd_data),
                             d_size(rd_data) - r_need - SIZE_W'(HEADER_BYTES));
            end else begin
                wr_addr = r_g;
                wr_data = mk(1'b1, 1'b0, d_hn(rd_data), d_next(rd_data), d_size(rd_data));
            end
        end
        if (r_state == S_HWAIT && r_op == OP_FREE && r_ptr != '0 && ptr_ok
            && d_mark(rd_data) && !d_hn(rd_data)) begin
            wr_en = 1'b1; wr_addr = offh[4 +: GW];
            wr_data = mk(1'b1, 1'b1, 1'b0, d_next(rd_data), d_size(rd_data));
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_base <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_base <= i_cfg_wr_data;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            r_state <= n_state;
            case (r_state)
                S_CLEAR: r_cnt <= r_cnt + 1'b1;
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_op  <= s_axis_tdata[1:0];
                    r_ptr <= s_axis_tdata[65:2];
                    r_req <= s_axis_tdata[97:66];
                    r_res <= '{ST_NULL, 64'd0, 1'b0, 64'd0, 19'd0};
                    r_realloc <= 1'b0;
                    r_after_free <= 1'b0;
                end
                S_DECODE: begin
                    r_need <= (need_w[32:SIZE_W] != '0) ? '1 : need_w[SIZE_W-1:0];
                    r_g <= '0;
                    r_cnt <= '0;
                    r_old <= offh[4 +: GW];
                    if (r_op == OP_NONE || (r_op == OP_FREE && r_ptr == '0)) begin
                        r_state <= S_OUT;
                    end else if (r_op != OP_ALLOC && r_ptr != '0 && !ptr_ok) begin
                        r_res.status <= ST_INVALID;
                        r_state <= S_OUT;
                    end else if ((r_op == OP_ALLOC || r_ptr == '0) && r_req == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_HWAIT: begin
                    r_oldd <= rd_data;
                    if (r_op == OP_ALLOC || r_ptr == '0) begin
                        r_cur <= rd_data;
                        r_state <= S_AWAIT;
                        // reuse the read just done for entry zero
                    end else if (!d_mark(rd_data)) begin
                        r_res.status <= ST_INVALID;
                        r_state <= S_OUT;
                    end else if (r_op == OP_FREE) begin
                        r_res.status <= ST_OK;
                        r_state <= d_hn(rd_data) ? S_FNEXT : S_OUT;
                    end else if (r_req == '0) begin
                        r_state <= d_hn(rd_data) ? S_FNEXT : S_OUT;
                        r_after_free <= 1'b1;
                        if (!d_hn(rd_data)) r_state <= S_FWAIT;
                    end else if ({5'd0, d_size(rd_data)} >= r_req) begin
                        r_res.status <= ST_OK;
                        r_res.result_pointer <= r_ptr;
                        r_state <= S_OUT;
                    end else begin
                        r_realloc <= 1'b1;
                        r_state <= S_AREAD;
                    end
                end
                S_AWAIT: begin
                    r_cur <= rd_data;
                    r_cnt <= r_cnt + 1'b1;
                    if (fits) begin
                        r_res.status <= ST_OK;
                        r_res.result_pointer <= uptr(r_base, r_g);
                        if (r_realloc) begin
                            r_res.copy_valid <= 1'b1;
                            r_res.copy_source <= r_ptr;
                            r_res.copy_length <= CLEN_W'(d_size(r_oldd));
                        end
                        if (split_ok) begin
                            r_cur <= mk(1'b1, 1'b0, 1'b1, ng_w[GW-1:0], r_need);
                            r_state <= S_SPLIT;
                        end else begin
                            r_state <= r_realloc ? S_FNEXT : S_OUT;
                        end
                    end else if (!d_hn(rd_data) || r_cnt == (GW+1)'(NGRAN-1)) begin
                        r_res.status <= ST_OOM;
                        r_state <= S_OUT;
                    end else begin
                        r_g <= d_next(rd_data);
                        r_state <= S_AREAD;
                    end
                end
                S_FNEXT: begin
                    // the old descriptor may have been rewritten by the allocation
                    if (r_realloc && r_old == r_g) r_oldd <= r_cur;
                    if (!d_hn(r_oldd) && !(r_realloc && r_old == r_g && d_hn(r_cur)))
                        r_state <= S_FWAIT;
                end
                S_FWAIT: if (r_after_free) r_res.status <= ST_NULL;
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {2'b00, r_res.copy_length, r_res.copy_source,
                           r_res.copy_valid, r_res.result_pointer, r_res.status};
endmodule
